### sv/rwlm_pkg.sv
package rwlm_pkg;

    localparam int unsigned REQUESTERS_DEF  = 16;
    localparam int unsigned MAX_NESTING_DEF = 255;

    localparam int unsigned ID_W     = 4;
    localparam int unsigned OP_W     = 2;
    localparam int unsigned RESP_W   = 3;
    localparam int unsigned STATE_W  = 2;
    localparam int unsigned WAKE_W   = 2;
    localparam int unsigned READERS_W = 12;

    localparam logic [READERS_W-1:0] READER_CAP = 12'd4095;

    localparam logic [OP_W-1:0] OP_READ_LOCK  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_LOCK = 2'd1;
    localparam logic [OP_W-1:0] OP_UNLOCK     = 2'd2;

    localparam logic [RESP_W-1:0] RESP_GRANTED       = 3'd0;
    localparam logic [RESP_W-1:0] RESP_WAIT          = 3'd1;
    localparam logic [RESP_W-1:0] RESP_WRITE_READING = 3'd2;
    localparam logic [RESP_W-1:0] RESP_NOT_HELD      = 3'd3;
    localparam logic [RESP_W-1:0] RESP_OVERFLOW      = 3'd4;

    localparam logic [STATE_W-1:0] LOCK_FREE  = 2'd0;
    localparam logic [STATE_W-1:0] LOCK_READ  = 2'd1;
    localparam logic [STATE_W-1:0] LOCK_WRITE = 2'd2;

    localparam logic [WAKE_W-1:0] WAKE_NONE    = 2'd0;
    localparam logic [WAKE_W-1:0] WAKE_WRITER  = 2'd1;
    localparam logic [WAKE_W-1:0] WAKE_READERS = 2'd2;

    typedef struct packed {
        logic [WAKE_W-1:0]  wake;
        logic [STATE_W-1:0] own_state;
        logic [STATE_W-1:0] lock_state;
        logic [RESP_W-1:0]  response;
    } result_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } fsm_state_t;

endpackage

### sv/reader_writer_lock_manager_core.sv
// Each accepted request reads its requester's read nesting from a one-port-read RAM,
// and once the output can take a new result the decision is made, written back and registered as the result.
// The result is offered once registered; no new request is taken until the previous
// one has been decided, written back and registered.
// While a result waits for m_tready, one more request is taken and held until it drains.
// Synchronous active-low reset clears all lock state and the per-entry valid bits.
module reader_writer_lock_manager_core #(
    parameter int unsigned REQUESTERS  = rwlm_pkg::REQUESTERS_DEF,
    parameter int unsigned MAX_NESTING = rwlm_pkg::MAX_NESTING_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // requester [3:0], operation [5:4], zero [7:6]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // response [2:0], lock_state [4:3], own_state [6:5],
                                   // wake [8:7], zero [15:9]
);

    localparam int unsigned AW = $clog2(REQUESTERS);
    localparam int unsigned NW = $clog2(MAX_NESTING + 1);
    localparam int unsigned XW = (AW > rwlm_pkg::ID_W) ? AW : rwlm_pkg::ID_W;

    rwlm_pkg::fsm_state_t            state_reg, state_next;
    logic [rwlm_pkg::ID_W-1:0]       requester_reg;
    logic [rwlm_pkg::OP_W-1:0]       operation_reg;
    logic [REQUESTERS-1:0]           valid_reg;
    logic                            m_tvalid_reg;
    rwlm_pkg::result_t               result_reg;

    logic                            accept;
    logic                            fire;
    logic [XW-1:0]                   in_ext;
    logic [XW-1:0]                   cur_ext;
    logic [AW-1:0]                   in_addr;
    logic [AW-1:0]                   cur_addr;
    logic [NW-1:0]                   ram_rdata;
    logic [NW-1:0]                   rd_nesting;
    logic                            nest_we;
    logic [NW-1:0]                   nest_wdata;
    rwlm_pkg::result_t               result;

    assign in_ext   = XW'(s_tdata[3:0]);
    assign cur_ext  = XW'(requester_reg);
    assign in_addr  = in_ext[AW-1:0];
    assign cur_addr = cur_ext[AW-1:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rwlm_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = rwlm_pkg::ST_EXEC;
                end
            end
            rwlm_pkg::ST_EXEC: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = rwlm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rwlm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        fire     = 1'b0;
        case (state_reg)
            rwlm_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            rwlm_pkg::ST_EXEC: begin
                fire = !m_tvalid_reg || m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= rwlm_pkg::ST_IDLE;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (fire && nest_we) begin
                valid_reg[cur_addr] <= 1'b1;
            end
            if (fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            requester_reg <= s_tdata[3:0];
            operation_reg <= s_tdata[5:4];
        end
        if (fire) begin
            result_reg <= result;
        end
    end

    rwlm_ram #(
        .WIDTH (NW),
        .DEPTH (REQUESTERS)
    ) u_nest_ram (
        .aclk  (aclk),
        .we    (fire && nest_we),
        .waddr (cur_addr),
        .wdata (nest_wdata),
        .re    (accept),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    assign rd_nesting = valid_reg[cur_addr] ? ram_rdata : '0;

    rwlm_engine #(
        .REQUESTERS  (REQUESTERS),
        .MAX_NESTING (MAX_NESTING)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .requester  (requester_reg),
        .operation  (operation_reg),
        .addr       (cur_addr),
        .rd_nesting (rd_nesting),
        .nest_we    (nest_we),
        .nest_wdata (nest_wdata),
        .result     (result)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, result_reg.wake, result_reg.own_state,
                       result_reg.lock_state, result_reg.response};

endmodule

### sv/rwlm_ram.sv
module rwlm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/rwlm_engine.sv
module rwlm_engine #(
    parameter int unsigned REQUESTERS  = rwlm_pkg::REQUESTERS_DEF,
    parameter int unsigned MAX_NESTING = rwlm_pkg::MAX_NESTING_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                fire,
    input  logic [rwlm_pkg::ID_W-1:0]           requester,
    input  logic [rwlm_pkg::OP_W-1:0]           operation,
    input  logic [$clog2(REQUESTERS)-1:0]       addr,
    input  logic [$clog2(MAX_NESTING+1)-1:0]    rd_nesting,
    output logic                                nest_we,
    output logic [$clog2(MAX_NESTING+1)-1:0]    nest_wdata,
    output rwlm_pkg::result_t                   result
);

    localparam int unsigned NW = $clog2(MAX_NESTING + 1);
    localparam int unsigned RW = rwlm_pkg::READERS_W;

    localparam logic [NW-1:0] NEST_MAX = NW'(MAX_NESTING);

    logic [RW-1:0]                 total_readers_reg, total_readers_next;
    logic [NW-1:0]                 writer_nesting_reg, writer_nesting_next;
    logic [rwlm_pkg::ID_W-1:0]     writer_owner_reg, writer_owner_next;
    logic [REQUESTERS-1:0]         waiting_writer_reg, waiting_writer_next;
    logic [REQUESTERS-1:0]         waiting_reader_reg, waiting_reader_next;

    logic                          known;
    logic [REQUESTERS-1:0]         me_bit;
    logic [REQUESTERS-1:0]         ww_clr;
    logic [REQUESTERS-1:0]         wr_clr;
    logic                          owns;
    logic                          grant;
    logic [NW-1:0]                 rn_next;
    logic [rwlm_pkg::RESP_W-1:0]   resp;
    logic [rwlm_pkg::WAKE_W-1:0]   wake;

    assign known  = 32'(requester) < 32'(REQUESTERS);
    assign me_bit = {{(REQUESTERS-1){1'b0}}, 1'b1} << addr;
    assign ww_clr = waiting_writer_reg & ~me_bit;
    assign wr_clr = waiting_reader_reg & ~me_bit;
    assign owns   = (writer_nesting_reg != '0) && (writer_owner_reg == requester);
    assign grant  = owns || (rd_nesting != '0) ||
                    ((writer_nesting_reg == '0) && !(|ww_clr));

    always_comb begin
        total_readers_next  = total_readers_reg;
        writer_nesting_next = writer_nesting_reg;
        writer_owner_next   = writer_owner_reg;
        waiting_writer_next = waiting_writer_reg;
        waiting_reader_next = waiting_reader_reg;
        rn_next             = rd_nesting;
        resp                = rwlm_pkg::RESP_GRANTED;
        wake                = rwlm_pkg::WAKE_NONE;
        nest_we             = 1'b0;

        if (!known) begin
            resp = rwlm_pkg::RESP_NOT_HELD;
        end else begin
            case (operation)
                rwlm_pkg::OP_READ_LOCK: begin
                    waiting_writer_next = ww_clr;
                    waiting_reader_next = wr_clr;
                    if (!grant) begin
                        resp                = rwlm_pkg::RESP_WAIT;
                        waiting_reader_next = wr_clr | me_bit;
                    end else if ((rd_nesting >= NEST_MAX) ||
                                 (total_readers_reg >= rwlm_pkg::READER_CAP)) begin
                        resp = rwlm_pkg::RESP_OVERFLOW;
                    end else begin
                        rn_next            = rd_nesting + NW'(1);
                        total_readers_next = total_readers_reg + RW'(1);
                        nest_we            = 1'b1;
                    end
                end
                rwlm_pkg::OP_WRITE_LOCK: begin
                    if ((total_readers_reg != '0) && (rd_nesting != '0)) begin
                        resp = rwlm_pkg::RESP_WRITE_READING;
                    end else begin
                        waiting_writer_next = ww_clr;
                        waiting_reader_next = wr_clr;
                        if ((total_readers_reg != '0) ||
                            ((writer_nesting_reg != '0) && (writer_owner_reg != requester))) begin
                            resp                = rwlm_pkg::RESP_WAIT;
                            waiting_writer_next = ww_clr | me_bit;
                        end else if (writer_nesting_reg >= NEST_MAX) begin
                            resp = rwlm_pkg::RESP_OVERFLOW;
                        end else begin
                            writer_owner_next   = requester;
                            writer_nesting_next = writer_nesting_reg + NW'(1);
                        end
                    end
                end
                rwlm_pkg::OP_UNLOCK: begin
                    if (total_readers_reg != '0) begin
                        if (rd_nesting == '0) begin
                            resp = rwlm_pkg::RESP_NOT_HELD;
                        end else begin
                            rn_next            = rd_nesting - NW'(1);
                            total_readers_next = total_readers_reg - RW'(1);
                            nest_we            = 1'b1;
                        end
                    end else if (owns) begin
                        writer_nesting_next = writer_nesting_reg - NW'(1);
                    end else begin
                        resp = rwlm_pkg::RESP_NOT_HELD;
                    end
                    if ((resp == rwlm_pkg::RESP_GRANTED) && (total_readers_next == '0) &&
                        (writer_nesting_next == '0)) begin
                        if (|waiting_writer_reg) begin
                            wake = rwlm_pkg::WAKE_WRITER;
                        end else if (|waiting_reader_reg) begin
                            wake = rwlm_pkg::WAKE_READERS;
                        end
                    end
                end
                default: begin
                    resp = rwlm_pkg::RESP_GRANTED;
                end
            endcase
        end
    end

    always_comb begin
        result.response = resp;
        result.wake     = wake;
        if (writer_nesting_next != '0) begin
            result.lock_state = rwlm_pkg::LOCK_WRITE;
        end else if (total_readers_next != '0) begin
            result.lock_state = rwlm_pkg::LOCK_READ;
        end else begin
            result.lock_state = rwlm_pkg::LOCK_FREE;
        end
        result.own_state = rwlm_pkg::LOCK_FREE;
        if (known) begin
            if ((writer_nesting_next != '0) && (writer_owner_next == requester)) begin
                result.own_state = rwlm_pkg::LOCK_WRITE;
            end else if ((total_readers_next != '0) && (rn_next != '0)) begin
                result.own_state = rwlm_pkg::LOCK_READ;
            end
        end
    end

    assign nest_wdata = rn_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_readers_reg  <= '0;
            writer_nesting_reg <= '0;
            writer_owner_reg   <= '0;
            waiting_writer_reg <= '0;
            waiting_reader_reg <= '0;
        end else if (fire) begin
            total_readers_reg  <= total_readers_next;
            writer_nesting_reg <= writer_nesting_next;
            writer_owner_reg   <= writer_owner_next;
            waiting_writer_reg <= waiting_writer_next;
            waiting_reader_reg <= waiting_reader_next;
        end
    end

endmodule
